>>> design/bdu_pkg.sv
// ----------------------------------------------------------------------------
// bdu_pkg
// shared types and constants for the box downsample unit
// ----------------------------------------------------------------------------
package bdu_pkg;

    localparam int MaxWidth  = 4096;
    localparam int MaxFactor = 8;
    localparam int ColW      = $clog2(MaxWidth);     // column address bits
    localparam int PosW      = 13;                   // position counter bits
    localparam int FacW      = 4;
    localparam int BlkW      = $clog2(MaxFactor);    // in-block counter bits
    localparam int SumW      = 14;                   // 64 * 255 fits in 14 bits
    localparam int RowW      = 11;                   // 8 * 255 fits in 11 bits

    typedef enum logic [1:0] {
        CFG_FACTOR = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item and advance counters
        logic rd;        // read column sum memory
        logic acc;       // update sums and write memory
        logic div_start; // unused; the datapath starts the divide unit itself
        logic out_load;  // move result to output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic emit;      // this item completes a block
        logic div_busy;
        logic lim_busy;  // whole-block limits still settling
    } t_sts;

endpackage

>>> design/bdu_div.sv
// ----------------------------------------------------------------------------
// bdu_div
// restoring divider, one quotient bit per cycle, 16 by 16 bits
// ----------------------------------------------------------------------------
module bdu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_busy,
    output logic [15:0] o_quo
);
    logic [15:0] r_quo, n_quo;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_den;
    logic [4:0]  r_cnt;
    logic [16:0] shifted;

    always_comb begin
        shifted = {r_rem[15:0], r_quo[15]};
        n_quo   = {r_quo[14:0], 1'b0};
        n_rem   = shifted;
        if (shifted >= {1'b0, r_den}) begin
            n_rem    = shifted - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 5'd16;
        end else if (r_cnt != 5'd0) begin
            r_cnt <= r_cnt - 5'd1;
        end
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != 5'd0) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != 5'd0);
    assign o_quo  = r_quo;
endmodule

>>> design/bdu_ctrl.sv
// ----------------------------------------------------------------------------
// bdu_ctrl
// sequencer for one item: read, accumulate, and for a block's last item divide and present
// ----------------------------------------------------------------------------
module bdu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_in_ready,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_out_free,
    input  bdu_pkg::t_sts i_sts,
    output bdu_pkg::t_cmd o_cmd
);
    bdu_pkg::t_state r_state, n_state;
    logic            take;

    // a config write goes first; items wait for settled limits
    assign take        = i_valid && !i_cfg_valid && !i_sts.lim_busy;
    assign o_cfg_ready = (r_state == bdu_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bdu_pkg::ST_IDLE: if (take) n_state = bdu_pkg::ST_READ;
            bdu_pkg::ST_READ: n_state = bdu_pkg::ST_ACC;
            bdu_pkg::ST_ACC:  n_state = i_sts.emit ? bdu_pkg::ST_DIV : bdu_pkg::ST_IDLE;
            bdu_pkg::ST_DIV:  if (!i_sts.div_busy) n_state = bdu_pkg::ST_OUT;
            bdu_pkg::ST_OUT:  if (i_out_free) n_state = bdu_pkg::ST_IDLE;
            default:          n_state = bdu_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            bdu_pkg::ST_IDLE: begin
                o_in_ready = !i_cfg_valid && !i_sts.lim_busy;
                o_cmd.load = take;
            end
            bdu_pkg::ST_READ: o_cmd.rd = 1'b1;
            bdu_pkg::ST_ACC:  o_cmd.acc = 1'b1;
            bdu_pkg::ST_DIV:  o_cmd.div_start = 1'b0;
            bdu_pkg::ST_OUT:  o_cmd.out_load = i_out_free;
            default: ;
        endcase
    end
endmodule

>>> design/bdu_dp.sv
// ----------------------------------------------------------------------------
// bdu_dp
// counters, line store of column sums, averaging and unpremultiply
// ----------------------------------------------------------------------------
module bdu_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [31:0]              i_cfg_data,
    input  logic [7:0]               i_in_red,
    input  logic [7:0]               i_in_green,
    input  logic [7:0]               i_in_blue,
    input  logic [7:0]               i_in_alpha,
    input  bdu_pkg::t_cmd            i_cmd,
    output bdu_pkg::t_sts            o_sts,
    output logic                     o_res_valid,
    input  logic                     i_res_take,
    output logic [7:0]               o_red,
    output logic [7:0]               o_green,
    output logic [7:0]               o_blue,
    output logic [7:0]               o_alpha,
    output logic                     o_row_end,
    output logic                     o_frame_end
);
    localparam int CW = bdu_pkg::ColW;
    localparam int PW = bdu_pkg::PosW;
    localparam int SW = bdu_pkg::SumW;

    logic [bdu_pkg::FacW-1:0] r_factor;
    logic [PW-1:0]            r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= 4'd1;
            r_width  <= 13'd1;
            r_height <= 13'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bdu_pkg::CFG_FACTOR: r_factor <= i_cfg_data[3:0];
                bdu_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[12:0];
                bdu_pkg::CFG_HEIGHT: r_height <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // effective sizes
    logic [3:0]  f;
    logic [PW-1:0] w, h;
    always_comb begin
        f = (r_factor == 4'd0) ? 4'd1 :
            (r_factor > 4'(bdu_pkg::MaxFactor)) ? 4'(bdu_pkg::MaxFactor) : r_factor;
        w = (r_width == '0) ? 13'd1 :
            (r_width > 13'(bdu_pkg::MaxWidth)) ? 13'(bdu_pkg::MaxWidth) : r_width;
        h = (r_height == '0) ? 13'd1 : r_height;
    end

    // whole-block limits, kept in registers (rebuilt after each config write)
    logic [PW-1:0] r_colw, r_rowh;    // ow*f, oh*f
    logic [PW-1:0] r_bc, r_br;        // block column and block row
    logic [PW-1:0] r_col, r_row;
    logic [2:0]    r_cib, r_rib;
    logic [PW-1:0] r_tr_w, r_tr_h;
    logic [PW-1:0] r_ow, r_oh;
    logic [PW:0]   nxt_w, nxt_h;      // one spare bit so the step never wraps

    assign nxt_w = {1'b0, r_tr_w} + {10'd0, f};
    assign nxt_h = {1'b0, r_tr_h} + {10'd0, f};

    // truncated sizes: quotients found incrementally while the block idles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tr_w <= '0;
            r_tr_h <= '0;
            r_ow   <= '0;
            r_oh   <= '0;
            r_colw <= '0;
            r_rowh <= '0;
        end else if (i_cfg_we) begin
            r_tr_w <= '0;
            r_tr_h <= '0;
            r_ow   <= '0;
            r_oh   <= '0;
            r_colw <= '0;
            r_rowh <= '0;
        end else begin
            if (nxt_w <= {1'b0, w}) begin
                r_tr_w <= nxt_w[PW-1:0];
                r_ow   <= r_ow + 13'd1;
            end
            if (nxt_h <= {1'b0, h}) begin
                r_tr_h <= nxt_h[PW-1:0];
                r_oh   <= r_oh + 13'd1;
            end
            r_colw <= r_tr_w;
            r_rowh <= r_tr_h;
        end
    end

    assign o_sts.lim_busy = (nxt_w <= {1'b0, w}) || (nxt_h <= {1'b0, h}) ||
                            (r_colw != r_tr_w) || (r_rowh != r_tr_h);

    // captured item and its position
    logic [7:0]    r_px [4];
    logic          r_inb, r_cend, r_rlast, r_first;
    logic [CW-1:0] r_addr;
    logic          r_rend, r_fend;
    logic          r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0; r_row <= '0; r_cib <= '0; r_rib <= '0;
            r_bc  <= '0; r_br  <= '0;
        end else if (i_cmd.load) begin
            if (r_col + 13'd1 >= w) begin
                r_col <= '0; r_cib <= '0; r_bc <= '0;
                if (r_row + 13'd1 >= h) begin
                    r_row <= '0; r_rib <= '0; r_br <= '0;
                end else begin
                    r_row <= r_row + 13'd1;
                    if ({1'b0, r_rib} + 4'd1 >= f) begin
                        r_rib <= '0;
                        r_br  <= r_br + 13'd1;
                    end else begin
                        r_rib <= r_rib + 3'd1;
                    end
                end
            end else begin
                r_col <= r_col + 13'd1;
                if ({1'b0, r_cib} + 4'd1 >= f) begin
                    r_cib <= '0;
                    r_bc  <= r_bc + 13'd1;
                end else begin
                    r_cib <= r_cib + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px[0] <= i_in_red;
            r_px[1] <= i_in_green;
            r_px[2] <= i_in_blue;
            r_px[3] <= i_in_alpha;
            r_inb   <= (r_col < r_colw) && (r_row < r_rowh);
            r_first <= (r_cib == 3'd0);
            r_cend  <= ({1'b0, r_cib} + 4'd1 >= f);
            r_rlast <= ({1'b0, r_rib} + 4'd1 >= f);
            r_addr  <= r_bc[CW-1:0];
            r_rend  <= (r_bc + 13'd1 == r_ow);
            r_fend  <= (r_br + 13'd1 == r_oh);
            r_top   <= (r_rib == 3'd0);
        end
    end

    // column sum store
    logic [4*SW-1:0] mem [bdu_pkg::MaxWidth];
    logic [4*SW-1:0] r_rd;
    logic [bdu_pkg::RowW-1:0] r_rps [4];
    logic [SW-1:0] r_sum [4];
    logic [SW-1:0] nsum [4];
    logic [bdu_pkg::RowW-1:0] nrps [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            nrps[c] = (r_first ? '0 : r_rps[c]) + {3'd0, r_px[c]};
            nsum[c] = (r_top ? '0 : r_rd[c*SW +: SW]) + {3'd0, nrps[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rd <= mem[r_addr];
        if (i_cmd.acc && r_inb && r_cend) begin
            mem[r_addr] <= {nsum[3], nsum[2], nsum[1], nsum[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 4; c++) r_rps[c] <= '0;
        end else if (i_cmd.acc && r_inb) begin
            for (int c = 0; c < 4; c++) r_rps[c] <= nrps[c];
        end
    end

    assign o_sts.emit = r_inb && r_cend && r_rlast;

    // divide sequence: 4 averages, then 3 unpremultiplies
    logic [2:0]  r_phase;
    logic        r_run, r_go;
    logic [7:0]  r_avg [4];
    logic [7:0]  r_res [3];
    logic [15:0] dnum, dden, dq;
    logic        dbusy;
    logic [6:0]  n_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) for (int c = 0; c < 4; c++) r_sum[c] <= nsum[c];
    end

    assign n_cnt = 7'(f) * 7'(f);

    always_comb begin
        if (r_phase < 3'd4) begin
            dnum = {2'd0, r_sum[2'(3 - r_phase)]} + {10'd0, n_cnt[6:1]};
            dden = {9'd0, n_cnt};
        end else begin
            dnum = {r_avg[2'(r_phase - 3'd4)], 8'd0} - {8'd0, r_avg[2'(r_phase - 3'd4)]}
                 + {9'd0, r_avg[3][7:1]};
            dden = {8'd0, r_avg[3]};
        end
    end

    bdu_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_go),
        .i_num  (dnum),
        .i_den  (dden),
        .o_busy (dbusy),
        .o_quo  (dq)
    );

    // phase p holds the channel that was just started; results land in order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_go    <= 1'b0;
            r_phase <= '0;
        end else begin
            r_go <= 1'b0;
            if (i_cmd.acc && o_sts.emit) begin
                r_run   <= 1'b1;
                r_go    <= 1'b1;
                r_phase <= '0;
            end else if (r_run && !r_go && !dbusy) begin
                if (r_phase < 3'd4) r_avg[2'(3 - r_phase)] <= dq[7:0];
                else r_res[2'(r_phase - 3'd4)] <= (dq > 16'd255) ? 8'd255 : dq[7:0];
                if (r_phase == 3'd6) begin
                    r_run <= 1'b0;
                end else begin
                    r_phase <= r_phase + 3'd1;
                    r_go    <= 1'b1;
                end
            end
        end
    end

    assign o_sts.div_busy = r_run;

    // output register
    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_res_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            for (int c = 0; c < 3; c++) begin
                logic [7:0] v;
                v = (r_avg[3] == 8'd0) ? 8'd0 :
                    (r_avg[3] == 8'd255) ? r_avg[c] : r_res[c];
                unique case (c)
                    0: o_red   <= v;
                    1: o_green <= v;
                    default: o_blue <= v;
                endcase
            end
            o_alpha     <= r_avg[3];
            o_row_end   <= r_rend;
            o_frame_end <= r_rend && r_fend;
        end
    end

    assign o_res_valid = r_ov;
endmodule

>>> design/box_downsample_unpremultiply_unit.sv
// ----------------------------------------------------------------------------
// box_downsample_unpremultiply_unit
// box-filter downsample of premultiplied rgba8 with unpremultiply
// ----------------------------------------------------------------------------
// an item that completes no block passes through accept, memory read and update
// an item that completes a block also runs through the shared one-bit-per-cycle
// divider (four averages, then three unpremultiplies) and is handed over to the
// output register; a full output register holds the unit back
// reset: synchronous active low, factor/width/height return to 1, counters to 0
// after a config write items wait while the block limits settle
module box_downsample_unpremultiply_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    input  logic [7:0]  i_in_alpha,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_alpha,
    output logic        o_row_end,
    output logic        o_frame_end
);
    bdu_pkg::t_cmd cmd;
    bdu_pkg::t_sts sts;
    logic          in_ready;
    logic          cfg_ready;
    logic          cfg_we;

    // config is taken only while no item is in flight
    assign o_cfg_ready = cfg_ready;
    assign cfg_we      = i_cfg_valid && cfg_ready;
    assign o_ready     = in_ready;

    bdu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_in_ready (in_ready),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_out_free (!o_valid || i_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bdu_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_red   (i_in_red),
        .i_in_green (i_in_green),
        .i_in_blue  (i_in_blue),
        .i_in_alpha (i_in_alpha),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_res_valid(o_valid),
        .i_res_take (i_ready),
        .o_red      (o_out_red),
        .o_green    (o_out_green),
        .o_blue     (o_out_blue),
        .o_alpha    (o_out_alpha),
        .o_row_end  (o_row_end),
        .o_frame_end(o_frame_end)
    );
endmodule

>>> design/bdu_checker.sv
// ----------------------------------------------------------------------------
// bdu_checker
// port-level checks for the downsample unit
// ----------------------------------------------------------------------------
module bdu_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_row_end,
    input logic o_frame_end
);
    // frame end only on a row end
    a_fend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_frame_end || o_row_end)) else $error("frame end without row end");

    // a pending result is held until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");

    // an accepted item is not followed by another accept the next cycle
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("back to back accept");
endmodule

bind box_downsample_unpremultiply_unit bdu_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_row_end  (o_row_end),
    .o_frame_end(o_frame_end)
);

>>> test/box_downsample_unpremultiply_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downsample_unpremultiply_unit_test
// drives whole frames of premultiplied rgba8 pixels through the box downsample
// unit under several factor and size settings, predicts every averaged and
// unpremultiplied output pixel, and checks each one field by field in order
// ----------------------------------------------------------------------------
module box_downsample_unpremultiply_unit_test;

    localparam int CycleLimit = 3000000;
    localparam int SettleWait = 4200;  // block limits settle after a config write
    localparam int TailWait   = 200;   // covers the longest item with no result

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       row_end;
        logic       frame_end;
    } t_out_pixel;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        bit         known;     // expected result typed in below
        t_out_pixel result;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_in_red = '0;
    logic [7:0]  i_in_green = '0;
    logic [7:0]  i_in_blue = '0;
    logic [7:0]  i_in_alpha = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic [7:0]  o_out_alpha;
    logic        o_row_end;
    logic        o_frame_end;

    box_downsample_unpremultiply_unit i_dut (.*);

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // mirror of the block: config, counters, column sum line store
    // ------------------------------------------------------------------
    int unsigned cfg_factor, cfg_width, cfg_height;
    int unsigned col_sum [bdu_pkg::MaxWidth][4];
    int unsigned seg_sum [4];
    int unsigned col_pos, row_pos, col_blk, row_blk;

    t_out_pixel pending_pixels[$];
    int         fail_count = 0;
    int         send_idle_pct = 0;   // chance of a gap before each item
    int         stall_pct = 0;       // chance of holding i_ready low
    int         cycle_count = 0;

    function automatic int unsigned factor_used();
        if (cfg_factor == 0) return 1;
        if (cfg_factor > bdu_pkg::MaxFactor) return bdu_pkg::MaxFactor;
        return cfg_factor;
    endfunction

    function automatic int unsigned width_used();
        if (cfg_width == 0) return 1;
        if (cfg_width > bdu_pkg::MaxWidth) return bdu_pkg::MaxWidth;
        return cfg_width;
    endfunction

    function automatic int unsigned height_used();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    // premultiplied color back to straight color
    function automatic logic [7:0] straight_color(int unsigned c, int unsigned a);
        int unsigned v;
        if (a == 0) return 8'd0;
        if (a >= 255) return c[7:0];
        v = (c * 255 + a / 2) / a;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic void clear_mirror();
        cfg_factor = 1;
        cfg_width  = 1;
        cfg_height = 1;
        foreach (col_sum[i, c]) col_sum[i][c] = 0;
        foreach (seg_sum[c]) seg_sum[c] = 0;
        col_pos = 0;
        row_pos = 0;
        col_blk = 0;
        row_blk = 0;
    endfunction

    // advance the mirror by one accepted pixel, queue the output pixel it completes
    function automatic void accumulate_pixel(logic [7:0] r, logic [7:0] g,
                                             logic [7:0] b, logic [7:0] a);
        int unsigned f, w, h, ow, oh, bc, n, prior;
        int unsigned px [4];
        int unsigned avg [4];
        t_out_pixel o;
        f = factor_used();
        w = width_used();
        h = height_used();
        ow = w / f;
        oh = h / f;
        px[0] = r; px[1] = g; px[2] = b; px[3] = a;
        if (col_pos < ow * f && row_pos < oh * f) begin
            bc = col_pos / f;
            if (col_blk == 0) foreach (seg_sum[c]) seg_sum[c] = 0;
            foreach (seg_sum[c]) seg_sum[c] += px[c];
            if (col_blk + 1 >= f && bc < bdu_pkg::MaxWidth) begin
                foreach (seg_sum[c]) begin
                    prior = (row_blk == 0) ? 0 : col_sum[bc][c];
                    col_sum[bc][c] = prior + seg_sum[c];
                end
                if (row_blk + 1 >= f) begin
                    n = f * f;
                    foreach (avg[c]) avg[c] = ((col_sum[bc][c] + n / 2) / n) & 8'hff;
                    o.red       = straight_color(avg[0], avg[3]);
                    o.green     = straight_color(avg[1], avg[3]);
                    o.blue      = straight_color(avg[2], avg[3]);
                    o.alpha     = avg[3][7:0];
                    o.row_end   = (bc + 1 == ow);
                    o.frame_end = o.row_end && (row_pos / f + 1 == oh);
                    pending_pixels.push_back(o);
                end
            end
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            col_blk = 0;
            if (row_pos + 1 >= h) begin
                row_pos = 0;
                row_blk = 0;
            end else begin
                row_pos++;
                row_blk = (row_blk + 1 >= f) ? 0 : row_blk + 1;
            end
        end else begin
            col_pos++;
            col_blk = (col_blk + 1 >= f) ? 0 : col_blk + 1;
        end
    endfunction

    // ------------------------------------------------------------------
    // output side: random stalls and in-order compare
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_pixel want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_pixels.size() == 0) begin
                    $error("output pixel with none expected");
                    fail_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (o_out_red !== want.red) begin
                        $error("out_red expected %0d got %0d", want.red, o_out_red);
                        fail_count++;
                    end
                    if (o_out_green !== want.green) begin
                        $error("out_green expected %0d got %0d", want.green, o_out_green);
                        fail_count++;
                    end
                    if (o_out_blue !== want.blue) begin
                        $error("out_blue expected %0d got %0d", want.blue, o_out_blue);
                        fail_count++;
                    end
                    if (o_out_alpha !== want.alpha) begin
                        $error("out_alpha expected %0d got %0d", want.alpha, o_out_alpha);
                        fail_count++;
                    end
                    if (o_row_end !== want.row_end) begin
                        $error("row_end expected %0d got %0d", want.row_end, o_row_end);
                        fail_count++;
                    end
                    if (o_frame_end !== want.frame_end) begin
                        $error("frame_end expected %0d got %0d", want.frame_end,
                               o_frame_end);
                        fail_count++;
                    end
                end
            end
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [7:0] a);
        // gaps lower valid; back-to-back items keep it high
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_in_red   <= r;
        i_in_green <= g;
        i_in_blue  <= b;
        i_in_alpha <= a;
        do @(posedge i_clk); while (!o_ready);
        accumulate_pixel(r, g, b, a);
    endtask

    task automatic send_random_pixel();
        logic [7:0] r, g, b, a;
        r = $urandom; g = $urandom; b = $urandom; a = $urandom;
        case ($urandom_range(0, 3))
            0: begin  // well-formed premultiplied color
                r = $urandom_range(0, a);
                g = $urandom_range(0, a);
                b = $urandom_range(0, a);
            end
            1: a = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            2: a = $urandom_range(0, 7);  // low alpha, heavy saturation
            default: ;
        endcase
        send_pixel(r, g, b, a);
    endtask

    // hold the input until every expected output pixel has arrived
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (TailWait) @(posedge i_clk);
    endtask

    task automatic write_reg(bdu_pkg::t_cfg_idx idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            bdu_pkg::CFG_FACTOR: cfg_factor = value & 32'hf;
            bdu_pkg::CFG_WIDTH:  cfg_width  = value & 32'h1fff;
            default:             cfg_height = value & 32'h1fff;
        endcase
    endtask

    // idle, reprogram all three registers, let the limits settle
    task automatic set_geometry(int unsigned f, int unsigned w, int unsigned h);
        wait_drained();
        write_reg(bdu_pkg::CFG_FACTOR, f);
        write_reg(bdu_pkg::CFG_WIDTH, w);
        write_reg(bdu_pkg::CFG_HEIGHT, h);
        repeat (SettleWait) @(posedge i_clk);
    endtask

    // idling mix: none, sender gaps, receiver stalls, both light
    function automatic void pick_idling(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 56; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 56; end
            default: begin send_idle_pct = 9; stall_pct = 9; end
        endcase
    endfunction

    // whole frames keep every line store read after its write
    task automatic send_frames(int unsigned frames);
        repeat (frames * width_used() * height_used()) send_random_pixel();
    endtask

    // under reset settings every pixel is its own block
    t_directed_row directed_rows [] = '{
        '{8'd0,   8'd0,   8'd0,   8'd0,   1, '{8'd0,   8'd0,   8'd0,   8'd0,   1, 1}},
        '{8'd255, 8'd255, 8'd255, 8'd255, 1, '{8'd255, 8'd255, 8'd255, 8'd255, 1, 1}},
        '{8'd10,  8'd20,  8'd30,  8'd0,   1, '{8'd0,   8'd0,   8'd0,   8'd0,   1, 1}},
        '{8'd1,   8'd2,   8'd3,   8'd255, 1, '{8'd1,   8'd2,   8'd3,   8'd255, 1, 1}},
        '{8'd255, 8'd255, 8'd255, 8'd1,   1, '{8'd255, 8'd255, 8'd255, 8'd1,   1, 1}},
        '{8'd0,   8'd0,   8'd0,   8'd1,   1, '{8'd0,   8'd0,   8'd0,   8'd1,   1, 1}},
        '{8'd200, 8'd200, 8'd200, 8'd100, 1, '{8'd255, 8'd255, 8'd255, 8'd100, 1, 1}},
        '{8'd254, 8'd0,   8'd0,   8'd254, 1, '{8'd255, 8'd0,   8'd0,   8'd254, 1, 1}},
        '{8'd100, 8'd0,   8'd255, 8'd128, 0, '{8'd0,   8'd0,   8'd0,   8'd0,   0, 0}},
        '{8'd64,  8'd32,  8'd16,  8'd128, 0, '{8'd0,   8'd0,   8'd0,   8'd0,   0, 0}},
        '{8'd170, 8'd85,  8'd0,   8'd170, 0, '{8'd0,   8'd0,   8'd0,   8'd0,   0, 0}},
        '{8'd1,   8'd1,   8'd1,   8'd2,   0, '{8'd0,   8'd0,   8'd0,   8'd0,   0, 0}}
    };

    initial begin
        int unsigned f, w, h, random_items, phase, sent;
        clear_mirror();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows, typed results replace the predicted ones
        foreach (directed_rows[k]) begin
            send_pixel(directed_rows[k].red, directed_rows[k].green,
                       directed_rows[k].blue, directed_rows[k].alpha);
            if (directed_rows[k].known) begin
                void'(pending_pixels.pop_back());
                pending_pixels.push_back(directed_rows[k].result);
            end
        end

        // special geometries: factor clamps, partial blocks, tiny source, zero sizes
        set_geometry(0, 4, 3);       send_frames(1);
        set_geometry(15, 17, 9);     send_frames(1);
        set_geometry(2, 5, 5);       send_frames(1);
        set_geometry(4, 3, 3);       send_frames(1);
        set_geometry(3, 0, 0);       send_frames(5);
        set_geometry(1, 0, 6);       send_frames(1);
        set_geometry(8, 16, 16);     send_frames(1);

        // random geometries, whole frames each
        random_items = 0;
        phase = 0;
        while (random_items < 970) begin
            case ($urandom_range(0, 9))
                0:       f = $urandom_range(9, 15);
                1:       f = 0;
                default: f = $urandom_range(1, 8);
            endcase
            w = (f == 0 ? 1 : (f > 8 ? 8 : f)) * $urandom_range(1, 5)
                + $urandom_range(0, 3);
            h = (f == 0 ? 1 : (f > 8 ? 8 : f)) * $urandom_range(1, 3)
                + $urandom_range(0, 2);
            set_geometry(f, w, h);
            pick_idling(phase);
            sent = 0;
            while (sent < 150) begin
                repeat (width_used() * height_used()) begin
                    // once, hold off mid-frame until the output side is empty
                    if (phase == 2 && sent == 40) wait_drained();
                    send_random_pixel();
                    sent++;
                end
            end
            random_items += sent;
            phase++;
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
design/bdu_pkg.sv
design/bdu_div.sv
design/bdu_ctrl.sv
design/bdu_dp.sv
design/box_downsample_unpremultiply_unit.sv
design/bdu_checker.sv
test/box_downsample_unpremultiply_unit_test.sv
